// ----- src/srtf_pkg.sv -----
// Shared constants and field layout for the shortest-remaining-time scheduler.
`default_nettype none

package srtf_pkg;

  // Table geometry
  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = 4;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Field widths
  localparam int VAL_W  = 16;
  localparam int TIME_W = 21;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Request kinds carried in s_tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Input beat layout: task_slot, arrival_time, burst_time
  localparam int I_SLOT_LSB = 0;
  localparam int I_ARR_LSB  = I_SLOT_LSB + SLOT_W;
  localparam int I_BUR_LSB  = I_ARR_LSB + VAL_W;
  localparam int I_USED_W   = I_BUR_LSB + VAL_W;
  localparam int IN_DATA_W  = ((I_USED_W + 7) / 8) * 8;

  // Output beat layout: task_id, slice_start, completion_time, turnaround, waiting, all_done
  localparam int O_ID_LSB    = 0;
  localparam int O_START_LSB = O_ID_LSB + SLOT_W;
  localparam int O_COMP_LSB  = O_START_LSB + TIME_W;
  localparam int O_TAT_LSB   = O_COMP_LSB + TIME_W;
  localparam int O_WAIT_LSB  = O_TAT_LSB + TIME_W;
  localparam int O_ALL_BIT   = O_WAIT_LSB + TIME_W;
  localparam int O_USED_W    = O_ALL_BIT + 1;
  localparam int OUT_DATA_W  = ((O_USED_W + 7) / 8) * 8;

  // Output tuser bits
  localparam int OU_RAN_BIT  = 0;
  localparam int OU_DONE_BIT = 1;
  localparam int OUT_USER_W  = 2;

  localparam int CFG_W = 5;

  typedef logic [TIME_W-1:0] tval_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [SLOT_W-1:0] slot_t;

endpackage

`default_nettype wire

// ----- src/shortest_remaining_time_scheduler.sv -----
// Preemptive shortest-remaining-time scheduler: task table, slot scan and result stage.
// Usage:
//   s_* stream: one beat per request. s_tuser is the kind (load or tick);
//   s_tdata carries the slot, arrival time and burst of a load.
//   m_* stream: exactly one result beat per request. m_tuser flags whether a
//   task ran and whether it finished; m_tdata holds the slot, slice start,
//   completion, turnaround, waiting time and the all-done status.
//   cfg_*: writes task_count (slots 0..min(task_count,16)-1 are scheduled); always
//   ready, write only while the block is idle.
// Timing:
//   Every request scans the slots in use one per cycle through a single
//   compare unit, then a tick passes the update and waiting-time states
//   before the result stage. One request is in flight at a time;
//   s_tready is high only when the sequencer is idle, so a new request
//   is taken only once the previous one has left the sequencer.
// Reset: all slots finished, clock zero, task_count zero, no result pending.
// Stall: a result waits in the output register while the next request is
//   accepted and processed; the sequencer holds its result until the output
//   register frees up.
`default_nettype none

module shortest_remaining_time_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // task_slot[3:0], arrival_time[19:4], burst_time[35:20], zero pad
  input  logic [srtf_pkg::IN_DATA_W-1:0] s_tdata,
  // req_type
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // task_id[3:0], slice_start[24:4], completion_time[45:25],
  // turnaround[66:46], waiting[87:67], all_done[88], zero pad
  output logic [srtf_pkg::OUT_DATA_W-1:0] m_tdata,
  // ran[0], task_done[1]
  output logic [srtf_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [srtf_pkg::CFG_W-1:0]     cfg_data_i
);
  import srtf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // Task tables
  val_t                 arr_mem [MAX_TASKS];
  val_t                 bur_mem [MAX_TASKS];
  val_t                 rem_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] fin_q;

  logic [2:0]       state_q;
  logic [CFG_W-1:0] cfg_q;
  logic             kind_q;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] uf_q;
  logic             found_q;
  slot_t            best_q;
  val_t             best_rem_q;
  tval_t            time_q;
  tval_t            start_q;
  logic             done_q;
  tval_t            tat_q;
  tval_t            wait_q;

  // Output register
  logic             m_valid_q;
  logic             o_ran_q;
  logic             o_done_q;
  logic             o_all_q;
  slot_t            o_id_q;
  tval_t            o_start_q;
  tval_t            o_comp_q;
  tval_t            o_tat_q;
  tval_t            o_wait_q;

  logic             s_acc;
  logic [CNT_W-1:0] n_use;
  slot_t            rd_idx;
  slot_t            rd_addr;
  logic [CNT_W-1:0] idx_inc;
  val_t             arr_rd_q;
  val_t             bur_rd_q;
  val_t             rem_rd_q;
  logic             fin_rd;
  logic             elig;
  tval_t            time_nx;
  tval_t            bur_ext;
  slot_t            ld_slot;
  val_t             ld_arr;
  val_t             ld_bur;
  logic             out_free;

  assign s_tready    = (state_q == ST_IDLE);
  assign s_acc       = s_tvalid && s_tready;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !m_valid_q || m_tready;

  assign ld_slot = s_tdata[I_SLOT_LSB +: SLOT_W];
  assign ld_arr  = s_tdata[I_ARR_LSB +: VAL_W];
  assign ld_bur  = s_tdata[I_BUR_LSB +: VAL_W];

  // Slots in use, capped at table size
  assign n_use = (cfg_q > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : cfg_q;

  // Finished flag of the slot under work: scan index, else the picked slot
  assign rd_idx = (state_q == ST_SCAN) ? idx_q[SLOT_W-1:0] : best_q;
  assign fin_rd = fin_q[rd_idx];

  // Table read address leads the scan index by one slot, so registered data lines up with the scan
  assign idx_inc = idx_q + CNT_W'(1);
  always_comb begin
    case (state_q)
      ST_IDLE: begin
        rd_addr = '0;
      end
      ST_SCAN: begin
        rd_addr = (idx_q == n_use) ? best_q : idx_inc[SLOT_W-1:0];
      end
      default: begin
        rd_addr = best_q;
      end
    endcase
  end

  // Registered table read
  always_ff @(posedge clk_i) begin
    arr_rd_q <= arr_mem[rd_addr];
    bur_rd_q <= bur_mem[rd_addr];
    rem_rd_q <= rem_mem[rd_addr];
  end

  // Shared compare: arrival against clock, remaining against best so far
  assign elig    = !fin_rd && (tval_t'(arr_rd_q) <= time_q);
  assign time_nx = (time_q == TIME_MAX) ? time_q : time_q + tval_t'(1);
  assign bur_ext = tval_t'(bur_rd_q);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Table storage
  always_ff @(posedge clk_i) begin
    if (s_acc && (s_tuser == REQ_LOAD)) begin
      arr_mem[ld_slot] <= ld_arr;
      bur_mem[ld_slot] <= ld_bur;
      rem_mem[ld_slot] <= ld_bur;
    end else if ((state_q == ST_UPD) && found_q) begin
      rem_mem[best_q] <= rem_rd_q - val_t'(1);
    end
  end

  // Finished flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= '1;
    end else if (s_acc && (s_tuser == REQ_LOAD)) begin
      fin_q[ld_slot] <= (ld_bur == '0);
    end else if ((state_q == ST_UPD) && found_q && (rem_rd_q == val_t'(1))) begin
      fin_q[best_q] <= 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      kind_q     <= REQ_LOAD;
      idx_q      <= '0;
      uf_q       <= '0;
      found_q    <= 1'b0;
      best_q     <= '0;
      best_rem_q <= '0;
      time_q     <= '0;
      start_q    <= '0;
      done_q     <= 1'b0;
      tat_q      <= '0;
      wait_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            kind_q  <= s_tuser;
            idx_q   <= '0;
            uf_q    <= '0;
            found_q <= 1'b0;
            best_q  <= '0;
            done_q  <= 1'b0;
            tat_q   <= '0;
            wait_q  <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_q == n_use) begin
            state_q <= (kind_q == REQ_TICK) ? ST_UPD : ST_OUT;
          end else begin
            if (!fin_rd) begin
              uf_q <= uf_q + CNT_W'(1);
            end
            if (elig && (!found_q || (rem_rd_q < best_rem_q))) begin
              best_q     <= idx_q[SLOT_W-1:0];
              best_rem_q <= rem_rd_q;
              found_q    <= 1'b1;
            end
            idx_q <= idx_inc;
          end
        end
        ST_UPD: begin
          start_q <= time_q;
          time_q  <= time_nx;
          if (found_q && (rem_rd_q == val_t'(1))) begin
            done_q <= 1'b1;
            tat_q  <= time_nx - tval_t'(arr_rd_q);
          end
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          // Waiting time, clamped at zero when the clock saturated
          wait_q  <= (tat_q >= bur_ext) ? tat_q - bur_ext : '0;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      o_ran_q   <= (kind_q == REQ_TICK) && found_q;
      o_id_q    <= ((kind_q == REQ_TICK) && found_q) ? best_q : '0;
      o_start_q <= (kind_q == REQ_TICK) ? start_q : '0;
      o_done_q  <= done_q;
      o_comp_q  <= done_q ? time_q : '0;
      o_tat_q   <= done_q ? tat_q : '0;
      o_wait_q  <= done_q ? wait_q : '0;
      o_all_q   <= ((uf_q - CNT_W'(done_q)) == '0);
    end
  end

  // Output packing
  always_comb begin
    m_tdata                          = '0;
    m_tdata[O_ID_LSB +: SLOT_W]      = o_id_q;
    m_tdata[O_START_LSB +: TIME_W]   = o_start_q;
    m_tdata[O_COMP_LSB +: TIME_W]    = o_comp_q;
    m_tdata[O_TAT_LSB +: TIME_W]     = o_tat_q;
    m_tdata[O_WAIT_LSB +: TIME_W]    = o_wait_q;
    m_tdata[O_ALL_BIT]               = o_all_q;
    m_tuser                          = '0;
    m_tuser[OU_RAN_BIT]              = o_ran_q;
    m_tuser[OU_DONE_BIT]             = o_done_q;
  end

  assign m_tvalid = m_valid_q;

endmodule

`default_nettype wire

// ----- src/srtf_checker.sv -----
// Port-level checks for the scheduler, bound to the top level.
`default_nettype none

module srtf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [srtf_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [srtf_pkg::OUT_USER_W-1:0] m_tuser
);
  import srtf_pkg::*;

  tval_t start_f;
  tval_t comp_f;
  slot_t id_f;

  assign start_f = m_tdata[O_START_LSB +: TIME_W];
  assign comp_f  = m_tdata[O_COMP_LSB +: TIME_W];
  assign id_f    = m_tdata[O_ID_LSB +: SLOT_W];

  // A stalled result stays presented
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped under stall");

  // One request at a time: no accept right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  // Completion only for a task that ran
  a_done_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[OU_DONE_BIT] |-> m_tuser[OU_RAN_BIT])
    else $error("completion without a running task");

  // No task reported when nothing ran
  a_idle_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser[OU_RAN_BIT] |-> (id_f == '0) && !m_tuser[OU_DONE_BIT])
    else $error("task id or done set on idle result");

  // A finished task completes one unit after its slice start
  a_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[OU_DONE_BIT] && (start_f != TIME_MAX)
      |-> comp_f == start_f + tval_t'(1))
    else $error("completion time does not follow slice start");

endmodule

bind shortest_remaining_time_scheduler srtf_checker u_srtf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- dv/shortest_remaining_time_scheduler_tb.sv -----
// Self-checking testbench for the shortest-remaining-time scheduler.
`timescale 1ns / 1ps

module shortest_remaining_time_scheduler_tb;
  import srtf_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_CAP     = 200;

  // One result beat, unpacked
  typedef struct packed {
    logic  ran;
    slot_t task_id;
    tval_t slice_start;
    logic  task_done;
    tval_t completion;
    tval_t turnaround;
    tval_t waiting;
    logic  all_done;
  } sched_outcome_t;

  // Mirror of the task table plus the queue of outcomes still owed by the block
  class srtf_scoreboard;
    logic [MAX_TASKS-1:0][VAL_W-1:0] arrival;
    logic [MAX_TASKS-1:0][VAL_W-1:0] burst;
    logic [MAX_TASKS-1:0][VAL_W-1:0] remaining;
    logic [MAX_TASKS-1:0]            finished;
    tval_t                           clock_now;
    logic [CFG_W-1:0]                task_count;
    sched_outcome_t                  outcomes_due[$];
    int errors, loads, ticks, slices, completions, idles;

    function new();
      arrival     = '0;
      burst       = '0;
      remaining   = '0;
      finished    = '1;
      clock_now   = '0;
      task_count  = '0;
      errors      = 0;
      loads       = 0;
      ticks       = 0;
      slices      = 0;
      completions = 0;
      idles       = 0;
    endfunction

    function void set_count(logic [CFG_W-1:0] value);
      task_count = value;
    endfunction

    // counts above the table size saturate
    function int in_use();
      return (task_count > MAX_TASKS) ? MAX_TASKS : int'(task_count);
    endfunction

    function bit all_finished();
      for (int i = 0; i < in_use(); i++)
        if (!finished[i]) return 1'b0;
      return 1'b1;
    endfunction

    // Apply one accepted request and queue the outcome it must produce
    function void schedule_request(logic req, slot_t slot, val_t arr, val_t bur);
      sched_outcome_t r;
      int             pick;
      bit             found;
      tval_t          tat;
      r     = '0;
      pick  = 0;
      found = 1'b0;
      if (req == REQ_LOAD) begin
        arrival[slot]   = arr;
        burst[slot]     = bur;
        remaining[slot] = bur;
        finished[slot]  = (bur == '0);
        loads++;
      end else begin
        ticks++;
        // least remaining among arrived, unfinished slots; ties keep the lower slot
        for (int i = 0; i < in_use(); i++) begin
          if (finished[i] || tval_t'(arrival[i]) > clock_now) continue;
          if (!found || remaining[i] < remaining[pick]) begin
            pick  = i;
            found = 1'b1;
          end
        end
        r.slice_start = clock_now;
        if (clock_now != TIME_MAX) clock_now = clock_now + 1'b1;
        if (found) begin
          slices++;
          r.ran           = 1'b1;
          r.task_id       = slot_t'(pick);
          remaining[pick] = remaining[pick] - 1'b1;
          if (remaining[pick] == '0) begin
            completions++;
            finished[pick] = 1'b1;
            tat            = clock_now - tval_t'(arrival[pick]);
            r.task_done    = 1'b1;
            r.completion   = clock_now;
            r.turnaround   = tat;
            r.waiting      = (tat >= tval_t'(burst[pick])) ? tat - tval_t'(burst[pick]) : '0;
          end
        end else begin
          idles++;
        end
      end
      r.all_done = all_finished();
      outcomes_due.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    // Check one result beat against the oldest outstanding outcome
    function void check_outcome(logic [OUT_USER_W-1:0] user, logic [OUT_DATA_W-1:0] data);
      sched_outcome_t want;
      sched_outcome_t got;
      got.ran         = user[OU_RAN_BIT];
      got.task_done   = user[OU_DONE_BIT];
      got.task_id     = data[O_ID_LSB +: SLOT_W];
      got.slice_start = data[O_START_LSB +: TIME_W];
      got.completion  = data[O_COMP_LSB +: TIME_W];
      got.turnaround  = data[O_TAT_LSB +: TIME_W];
      got.waiting     = data[O_WAIT_LSB +: TIME_W];
      got.all_done    = data[O_ALL_BIT];
      if (outcomes_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result beat with nothing pending, expected none actual tuser %h tdata %h",
                   $time, user, data);
        return;
      end
      want = outcomes_due.pop_front();
      compare_field("ran", want.ran, got.ran);
      compare_field("task_id", want.task_id, got.task_id);
      compare_field("slice_start", want.slice_start, got.slice_start);
      compare_field("task_done", want.task_done, got.task_done);
      compare_field("completion_time", want.completion, got.completion);
      compare_field("turnaround", want.turnaround, got.turnaround);
      compare_field("waiting", want.waiting, got.waiting);
      compare_field("all_done", want.all_done, got.all_done);
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_n;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [OUT_USER_W-1:0]  m_tuser;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i;

  srtf_scoreboard sb;
  int             burst_left = 0;
  int             settings   = 0;

  shortest_remaining_time_scheduler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver backpressure: a rotating 16-bit ready mask, redrawn at random when its age counter wraps
  logic [15:0] ready_mask = 16'hFFFF;
  int          mask_age   = 0;
  always @(posedge clk_i) begin
    mask_age++;
    if (mask_age == 64) begin
      mask_age = 0;
      case ($urandom_range(3))
        0: ready_mask = 16'hFFFF;
        1: ready_mask = 16'($urandom);
        2: ready_mask = 16'h0001 << $urandom_range(15);
        default: ready_mask = 16'($urandom | $urandom);
      endcase
      if (ready_mask == '0) ready_mask = 16'h8000;
    end
    m_tready   <= ready_mask[0];
    ready_mask = {ready_mask[0], ready_mask[15:1]};
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_n && m_tvalid && m_tready) sb.check_outcome(m_tuser, m_tdata);
  end

  // Watchdog on cycles with no beat on any channel
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer one request; the sender runs in bursts separated by random gaps
  task automatic send_request(logic req, slot_t slot, val_t arr, val_t bur);
    logic [IN_DATA_W-1:0] data;
    int                   gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    data                        = '0;
    data[I_SLOT_LSB +: SLOT_W]  = slot;
    data[I_ARR_LSB +: VAL_W]    = arr;
    data[I_BUR_LSB +: VAL_W]    = bur;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= data;
    do @(posedge clk_i); while (!s_tready);
    sb.schedule_request(req, slot, arr, bur);
  endtask

  task automatic load_task(slot_t slot, val_t arr, val_t bur);
    send_request(REQ_LOAD, slot, arr, bur);
  endtask

  // tick payload is don't-care, so fill it with noise
  task automatic tick();
    send_request(REQ_TICK, slot_t'($urandom), val_t'($urandom), val_t'($urandom));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.outcomes_due.size() != 0);
  endtask

  task automatic write_task_count(logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_count(value);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // arrival mostly near the current clock so tasks become eligible soon
  function automatic val_t pick_arrival();
    int now;
    int lo;
    int hi;
    int roll;
    now  = int'(sb.clock_now);
    lo   = (now > 8) ? now - 8 : 0;
    hi   = (now + 12 > 65535) ? 65535 : now + 12;
    roll = $urandom_range(99);
    if (roll < 70) return val_t'($urandom_range(hi, lo));
    if (roll < 85) return val_t'($urandom);
    return '0;
  endfunction

  function automatic val_t pick_burst();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8)  return '0;
    if (roll < 80) return val_t'($urandom_range(6, 1));
    if (roll < 90) return val_t'($urandom_range(40, 7));
    return val_t'($urandom);
  endfunction

  task automatic random_request();
    slot_t slot;
    if ($urandom_range(99) < 27) begin
      if (sb.in_use() > 0 && $urandom_range(99) < 85) slot = slot_t'($urandom_range(sb.in_use() - 1));
      else slot = slot_t'($urandom);
      load_task(slot, pick_arrival(), pick_burst());
    end else begin
      tick();
    end
  endtask

  int phase_counts[10] = '{16, 1, 31, 2, 0, 8, 17, 5, 16, 3};

  initial begin
    rst_n       = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = REQ_LOAD;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    sb          = new();
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // No slots in use: idle tick, and a load that is stored but not scheduled
    tick();
    load_task(4'd15, 16'hFFFF, 16'hFFFF);
    drain();

    // Four slots: tie on remaining time, late arrival with a short burst, never-arriving task
    write_task_count(5'd4);
    load_task(4'd0, 16'd0, 16'd3);
    load_task(4'd1, 16'd0, 16'd3);
    load_task(4'd2, 16'hFFFF, 16'hFFFF);
    load_task(4'd3, 16'd2, 16'd1);
    repeat (4) tick();
    // zero burst retires the blocking slot at once
    load_task(4'd2, 16'd0, 16'd0);
    repeat (4) tick();
    // overwrite a task that is still running
    load_task(4'd0, 16'd0, 16'd5);
    tick();
    load_task(4'd0, 16'd0, 16'd2);
    repeat (3) tick();
    drain();

    // Random phases; each starts by filling the slots in use, then mixes loads and ticks
    foreach (phase_counts[p]) begin
      write_task_count(CFG_W'(phase_counts[p]));
      for (int s = 0; s < sb.in_use(); s++)
        load_task(slot_t'(s), pick_arrival(), val_t'($urandom_range(8, 1)));
      repeat (90) random_request();
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("Ran %0d loads and %0d ticks over %0d task_count settings,",
             sb.loads, sb.ticks, settings);
    $display("with %0d slices run, %0d tasks completed and %0d idle ticks.",
             sb.slices, sb.completions, sb.idles);
    if (sb.errors == 0 && sb.outcomes_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
